FILE: design/rmth_pkg.sv
// Package for the running median block: widths, depths, sequencer states.
// No dependencies.
package rmth_pkg;
    localparam int CAPACITY     = 1024;
    localparam int SAMPLE_WIDTH = 32;
    localparam int HEAP_DEPTH   = (CAPACITY + 1) / 2;
    localparam int AW           = $clog2(HEAP_DEPTH);
    localparam int CW           = $clog2(HEAP_DEPTH + 1);
    localparam int TW           = $clog2(CAPACITY + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_cnt;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_PUSH_RD, S_PUSH_CMP,
        S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_WAIT, S_FIN_RD, S_FIN_WAIT, S_OUT
    } t_state;

    // Compare: true when a belongs above b in the heap.
    function automatic logic above(input t_sample a, input t_sample b, input logic is_max);
        above = is_max ? (a > b) : (a < b);
    endfunction
endpackage

FILE: design/rmth_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/running_median_two_heaps.sv
// Top level of the running lower median block: sequencer, two heap RAMs.
// Depends on rmth_pkg and rmth_ram.
//
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_restart, i_sample_value
//  output  | o_valid | i_stall | o_median_value, o_sample_count, o_full_res
//
// A push that stays at its leaf is written and done. Each level a pushed value rises
// takes a read of the parent and a compare. A replaced root sinks level by level (read
// left child, read right child, compare), and the old root is then pushed into the other half.
// In the worst case the root sinks through every level of one heap and the moved root
// then rises through every level of the other. There is a single RAM port per heap, so
// every level needs a read before its compare.
// Reset empties both halves at once (counts only). The block takes no new item while
// one is in work or its result waits; a stalled result holds until it is taken.
module running_median_two_heaps (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    input  rmth_pkg::t_sample i_sample_value,
    output logic        o_valid,
    input  logic        i_stall,
    output rmth_pkg::t_sample o_median_value,
    output logic [rmth_pkg::TW-1:0] o_sample_count,
    output logic        o_full_res
);
    typedef rmth_pkg::t_sample t_sample;
    typedef rmth_pkg::t_addr   t_addr;
    typedef rmth_pkg::t_cnt    t_cnt;

    rmth_pkg::t_state r_state, n_state;
    t_cnt    r_lcnt, n_lcnt, r_ucnt, n_ucnt;
    t_sample r_v, n_v;            // value being sifted
    t_sample r_mv, n_mv;          // value moved across for the final push
    t_sample r_ltop, n_ltop, r_utop, n_utop; // cached roots
    t_sample r_lch, n_lch;        // left child during sift-down
    logic    r_sel, n_sel;        // heap in work: 1 lower (max), 0 upper
    logic    r_fsel, n_fsel;      // heap that takes the moved root
    logic [rmth_pkg::CW:0] r_pos, n_pos;
    logic [rmth_pkg::CW:0] r_n, n_n;
    logic    r_full, n_full;

    logic    l_we, u_we;
    t_addr   l_addr, u_addr;
    t_sample l_wd, u_wd, l_rd, u_rd, rd;
    logic    we;
    t_addr   addr;
    t_sample wd;

    rmth_ram #(.WIDTH(rmth_pkg::SAMPLE_WIDTH), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_lower (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wd), .o_rdata(l_rd));
    rmth_ram #(.WIDTH(rmth_pkg::SAMPLE_WIDTH), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_upper (
        .i_clk(i_clk), .i_we(u_we), .i_addr(u_addr), .i_wdata(u_wd), .o_rdata(u_rd));

    // Route the single shared port to the heap in work.
    assign l_we   = we & r_sel;
    assign u_we   = we & ~r_sel;
    assign l_addr = addr;
    assign u_addr = addr;
    assign l_wd   = wd;
    assign u_wd   = wd;
    assign rd     = r_sel ? l_rd : u_rd;

    assign o_stall        = (r_state != rmth_pkg::S_IDLE);
    assign o_valid        = (r_state == rmth_pkg::S_OUT);
    assign o_median_value = r_ltop;
    assign o_sample_count = rmth_pkg::TW'(r_lcnt) + rmth_pkg::TW'(r_ucnt);
    assign o_full_res     = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmth_pkg::S_IDLE;
            r_lcnt  <= '0;
            r_ucnt  <= '0;
        end else begin
            r_state <= n_state;
            r_lcnt  <= n_lcnt;
            r_ucnt  <= n_ucnt;
        end
        r_v <= n_v; r_mv <= n_mv; r_ltop <= n_ltop; r_utop <= n_utop;
        r_lch <= n_lch; r_sel <= n_sel; r_fsel <= n_fsel;
        r_pos <= n_pos; r_n <= n_n; r_full <= n_full;
    end

    logic [rmth_pkg::CW:0] par, lc, rc;
    t_sample best;
    logic    take_l, take_r;
    t_sample top_cur;

    always_comb begin
        n_state = r_state; n_lcnt = r_lcnt; n_ucnt = r_ucnt;
        n_v = r_v; n_mv = r_mv; n_ltop = r_ltop; n_utop = r_utop; n_lch = r_lch;
        n_sel = r_sel; n_fsel = r_fsel; n_pos = r_pos;
        n_n = r_n; n_full = r_full;
        we = 1'b0; addr = '0; wd = r_v;
        par = (r_pos - 1'b1) >> 1;
        lc  = {r_pos[rmth_pkg::CW-1:0], 1'b1};
        rc  = lc + 1'b1;
        top_cur = r_sel ? r_ltop : r_utop;
        take_l = 1'b0; take_r = 1'b0; best = r_v;
        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_restart) begin
                        n_lcnt = '0;
                        n_ucnt = '0;
                    end
                    n_v = i_sample_value;
                    n_full = 1'b0;
                    n_state = rmth_pkg::S_DECIDE;
                end
            end
            rmth_pkg::S_DECIDE: begin
                if (rmth_pkg::TW'(r_lcnt) + rmth_pkg::TW'(r_ucnt)
                        >= rmth_pkg::TW'(rmth_pkg::CAPACITY)) begin
                    n_full = 1'b1;
                    n_state = rmth_pkg::S_OUT;
                end else begin
                    n_pos = '0;
                    n_state = rmth_pkg::S_PUSH_CMP;
                    if (r_lcnt == '0) begin
                        n_sel = 1'b1;
                    end else if (r_ltop > r_v) begin
                        if (r_lcnt > r_ucnt) begin
                            // Replace the lower root; old root moves up.
                            n_sel = 1'b1; n_mv = r_ltop; n_fsel = 1'b0;
                            n_n = (rmth_pkg::CW+1)'(r_lcnt);
                            n_state = rmth_pkg::S_DN_RDL;
                        end else begin
                            n_sel = 1'b1;
                        end
                    end else if (r_ucnt >= r_lcnt) begin
                        if (r_ucnt == '0 || r_v <= r_utop) begin
                            n_sel = 1'b1;
                        end else begin
                            n_sel = 1'b0; n_mv = r_utop; n_fsel = 1'b1;
                            n_n = (rmth_pkg::CW+1)'(r_ucnt);
                            n_state = rmth_pkg::S_DN_RDL;
                        end
                    end else begin
                        n_sel = 1'b0;
                    end
                    if (n_state == rmth_pkg::S_PUSH_CMP) begin
                        // Push: start at the new leaf, bump count.
                        n_pos = n_sel ? (rmth_pkg::CW+1)'(r_lcnt) : (rmth_pkg::CW+1)'(r_ucnt);
                        if (n_sel) n_lcnt = r_lcnt + 1'b1; else n_ucnt = r_ucnt + 1'b1;
                        n_state = rmth_pkg::S_PUSH_RD;
                    end
                end
            end
            rmth_pkg::S_PUSH_RD: begin
                // Read the parent, or place at the root.
                if (r_pos == '0) begin
                    we = 1'b1; addr = '0;
                    if (r_sel) n_ltop = r_v; else n_utop = r_v;
                    n_state = rmth_pkg::S_OUT;
                end else begin
                    addr = t_addr'(par);
                    n_state = rmth_pkg::S_PUSH_CMP;
                end
            end
            rmth_pkg::S_PUSH_CMP: begin
                addr = t_addr'(r_pos);
                we = 1'b1;
                if (rmth_pkg::above(r_v, rd, r_sel)) begin
                    wd = rd;            // drop parent down
                    n_pos = par;
                    n_state = rmth_pkg::S_PUSH_RD;
                end else begin
                    wd = r_v;
                    n_state = rmth_pkg::S_OUT;
                end
            end
            rmth_pkg::S_DN_RDL: begin
                if (lc >= r_n) begin
                    addr = t_addr'(r_pos); we = 1'b1; wd = r_v;
                    if (r_pos == '0) begin
                        if (r_sel) n_ltop = r_v; else n_utop = r_v;
                    end
                    n_state = rmth_pkg::S_FIN_RD;
                end else begin
                    addr = t_addr'(lc);
                    n_state = rmth_pkg::S_DN_RDR;
                end
            end
            rmth_pkg::S_DN_RDR: begin
                n_lch = rd;
                addr = t_addr'(rc);
                n_state = rmth_pkg::S_DN_CMP;
            end
            rmth_pkg::S_DN_CMP: begin
                if (rmth_pkg::above(r_lch, r_v, r_sel)) begin
                    take_l = 1'b1; best = r_lch;
                end
                if (rc < r_n && rmth_pkg::above(rd, best, r_sel)) begin
                    take_r = 1'b1; take_l = 1'b0; best = rd;
                end
                addr = t_addr'(r_pos); we = 1'b1;
                wd = (take_l || take_r) ? best : r_v;
                if (r_pos == '0) begin
                    if (r_sel) n_ltop = wd; else n_utop = wd;
                end
                if (take_r) begin
                    n_pos = rc; n_state = rmth_pkg::S_DN_WAIT;
                end else if (take_l) begin
                    n_pos = lc; n_state = rmth_pkg::S_DN_WAIT;
                end else begin
                    n_state = rmth_pkg::S_FIN_RD;
                end
            end
            rmth_pkg::S_DN_WAIT: begin
                n_state = rmth_pkg::S_DN_RDL;
            end
            rmth_pkg::S_FIN_RD: begin
                // Start the push of the moved root into the other heap.
                n_sel = r_fsel; n_v = r_mv;
                n_pos = r_fsel ? (rmth_pkg::CW+1)'(r_lcnt) : (rmth_pkg::CW+1)'(r_ucnt);
                if (r_fsel) n_lcnt = r_lcnt + 1'b1; else n_ucnt = r_ucnt + 1'b1;
                n_state = rmth_pkg::S_FIN_WAIT;
            end
            rmth_pkg::S_FIN_WAIT: begin
                n_state = rmth_pkg::S_PUSH_RD;
            end
            rmth_pkg::S_OUT: begin
                if (!i_stall) n_state = rmth_pkg::S_IDLE;
            end
            default: n_state = rmth_pkg::S_IDLE;
        endcase
        if (r_state == rmth_pkg::S_OUT) wd = top_cur;
    end
endmodule
